// ===== hdl/sorted_cell_region_labeler_macros.svh =====
// Assertion macros used by the checker of the region labeler.
`ifndef SORTED_CELL_REGION_LABELER_MACROS_SVH
`define SORTED_CELL_REGION_LABELER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SCRL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SCRL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/scrl_pkg.sv =====
// Shared constants, payload types and tables of the sorted cell region labeler.
package scrl_pkg;

  localparam int GRID_WIDTH   = 256;
  localparam int GRID_HEIGHT  = 256;
  localparam int MAX_SEGMENTS = 4096;
  localparam int VALUE_BITS   = 16;

  localparam int COORD_W = 8;
  localparam int ID_W    = 13;
  localparam int CLASS_W = 2;
  localparam int CELLS   = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int SEG_AW  = $clog2(MAX_SEGMENTS);
  localparam int NB_W    = 3;
  localparam int HITS_W  = 2;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_PICK_LOWER = 3'd0;

  localparam logic [CLASS_W-1:0] CLS_INTERIOR = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_BOUNDARY = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_SEED     = 2'd2;
  localparam logic [CLASS_W-1:0] CLS_NODATA   = 2'd3;

  // Neighbour walk: (0,+1) (+1,+1) (+1,0) (+1,-1) (0,-1) (-1,-1) (-1,0) (-1,+1)
  localparam logic signed [1:0] NB_DX [8] = '{2'sd0, 2'sd1, 2'sd1, 2'sd1,
                                              2'sd0, -2'sd1, -2'sd1, -2'sd1};
  localparam logic signed [1:0] NB_DY [8] = '{2'sd1, 2'sd1, 2'sd0, -2'sd1,
                                              -2'sd1, -2'sd1, 2'sd0, 2'sd1};

  typedef struct packed {
    logic [COORD_W-1:0]           cell_x;
    logic [COORD_W-1:0]           cell_y;
    logic signed [VALUE_BITS-1:0] cell_value;
    logic                         cell_valid;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]              segment_id;
    logic signed [VALUE_BITS-1:0] seed_value;
    logic [CLASS_W-1:0]           feature_class;
    logic                         overflow;
  } out_item_t;

  // One word of the cell store: label and sample of a grid position.
  typedef struct packed {
    logic [ID_W-1:0]              label;
    logic signed [VALUE_BITS-1:0] value;
  } cell_entry_t;

  typedef struct packed {
    logic clear;
    logic eval;
  } pick_ctrl_t;

endpackage

// ===== hdl/sorted_cell_region_labeler.sv =====
// Top level of the sorted cell region labeler: sequencer, stores and config port.
//
// Cells are taken one at a time in sorted order. After reset all 65536 entries of the
// cell store are cleared, one per cycle; input stays stalled meanwhile (config writes
// are taken). For a valid in-grid cell the single port of the cell store then reads
// the eight neighbours on consecutive cycles while the shared compare unit folds each
// in-grid one into the best label in the cycle after its read; then the cell is written
// back and its segment seed is read from the seed table. An invalid cell skips the
// scan, a cell outside the grid goes straight to the result. A new cell is accepted only
// once the previous result is in the output register; a stalled output holds the block.
module sorted_cell_region_labeler (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  scrl_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output scrl_pkg::out_item_t              out_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [scrl_pkg::PADDR_W-1:0]     paddr,
  input  logic [scrl_pkg::PDATA_W-1:0]     pwdata,
  output logic [scrl_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);

  localparam int CW = scrl_pkg::COORD_W + 2;
  localparam int AW = scrl_pkg::ADDR_W;
  localparam int EW = $bits(scrl_pkg::cell_entry_t);
  localparam logic [AW-1:0] LAST_ADDR = AW'(scrl_pkg::CELLS - 1);
  localparam logic [scrl_pkg::NB_W-1:0] LAST_NB = '1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_LAST  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_SEED  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]                             state;
  logic [2:0]                             state_next;
  logic [AW-1:0]                          clr_addr;
  logic [scrl_pkg::NB_W-1:0]              nb_idx;
  logic                                   rd_pend;
  logic                                   pick_lower;
  logic [scrl_pkg::ID_W-1:0]              segment_count;

  logic [scrl_pkg::COORD_W-1:0]           cur_x;
  logic [scrl_pkg::COORD_W-1:0]           cur_y;
  logic signed [scrl_pkg::VALUE_BITS-1:0] cur_value;
  logic                                   cur_valid;
  logic [AW-1:0]                          cur_pos;

  logic [scrl_pkg::ID_W-1:0]              res_id;
  logic signed [scrl_pkg::VALUE_BITS-1:0] res_seed;
  logic [scrl_pkg::CLASS_W-1:0]           res_cls;
  logic                                   res_ovf;
  logic                                   res_join;

  logic                                   in_accept;
  logic                                   out_free;
  logic                                   in_off_grid;
  logic [AW-1:0]                          in_pos;

  logic signed [CW-1:0]                   nx;
  logic signed [CW-1:0]                   ny;
  logic                                   nb_in_grid;
  logic [AW-1:0]                          nb_pos;

  logic                                   cell_we;
  logic [AW-1:0]                          cell_addr;
  scrl_pkg::cell_entry_t                  cell_wdata;
  logic [EW-1:0]                          cell_rdata_raw;
  scrl_pkg::cell_entry_t                  cell_rdata;

  logic                                   seed_we;
  logic [scrl_pkg::SEG_AW-1:0]            seed_addr;
  logic [scrl_pkg::ID_W-1:0]              best_m1;
  logic signed [scrl_pkg::VALUE_BITS-1:0] seed_rdata;

  scrl_pkg::pick_ctrl_t                   pick_ctrl;
  logic [scrl_pkg::ID_W-1:0]              best_label;
  logic [scrl_pkg::HITS_W-1:0]            hits;

  logic [scrl_pkg::ID_W-1:0]              wr_label;
  logic [scrl_pkg::CLASS_W-1:0]           wr_cls;
  logic                                   wr_ovf;
  logic                                   wr_join;
  logic                                   wr_new;
  logic                                   table_full;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == scrl_pkg::REG_PICK_LOWER) ?
                  {{(scrl_pkg::PDATA_W-1){1'b0}}, pick_lower} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pick_lower <= 1'b0;
    end else if (psel && penable && pwrite && (paddr == scrl_pkg::REG_PICK_LOWER)) begin
      pick_lower <= pwdata[0];
    end
  end

  // Handshakes
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign in_off_grid = (int'(in_data.cell_x) >= scrl_pkg::GRID_WIDTH) ||
                       (int'(in_data.cell_y) >= scrl_pkg::GRID_HEIGHT);
  assign in_pos = AW'(in_data.cell_x) + AW'(in_data.cell_y) * AW'(scrl_pkg::GRID_WIDTH);

  // Neighbour address generation
  assign nx = signed'({2'b00, cur_x}) + CW'(scrl_pkg::NB_DX[nb_idx]);
  assign ny = signed'({2'b00, cur_y}) + CW'(scrl_pkg::NB_DY[nb_idx]);
  assign nb_in_grid = !nx[CW-1] && !ny[CW-1] &&
                      (int'(nx) < scrl_pkg::GRID_WIDTH) && (int'(ny) < scrl_pkg::GRID_HEIGHT);
  assign nb_pos = AW'(nx[scrl_pkg::COORD_W-1:0]) +
                  AW'(ny[scrl_pkg::COORD_W-1:0]) * AW'(scrl_pkg::GRID_WIDTH);

  // Write-back decision
  assign table_full = (segment_count >= scrl_pkg::ID_W'(scrl_pkg::MAX_SEGMENTS));

  always_comb begin
    wr_label = '0;
    wr_cls   = scrl_pkg::CLS_NODATA;
    wr_ovf   = 1'b0;
    wr_join  = 1'b0;
    wr_new   = 1'b0;
    if (cur_valid) begin
      if (hits == '0) begin
        wr_cls = scrl_pkg::CLS_SEED;
        if (table_full) begin
          wr_ovf = 1'b1;
        end else begin
          wr_new   = 1'b1;
          wr_label = segment_count + 1'b1;
        end
      end else begin
        wr_join  = 1'b1;
        wr_label = best_label;
        wr_cls   = (hits == 2'd1) ? scrl_pkg::CLS_INTERIOR : scrl_pkg::CLS_BOUNDARY;
      end
    end
  end

  // Cell store port
  always_comb begin
    cell_we          = 1'b0;
    cell_addr        = cur_pos;
    cell_wdata.label = wr_label;
    cell_wdata.value = cur_value;
    case (state)
      S_CLEAR: begin
        cell_we          = 1'b1;
        cell_addr        = clr_addr;
        cell_wdata.label = '0;
      end
      S_SCAN: begin
        cell_addr = nb_pos;
      end
      S_WRITE: begin
        cell_we = 1'b1;
      end
      default: begin
        cell_addr = cur_pos;
      end
    endcase
  end

  assign cell_rdata = scrl_pkg::cell_entry_t'(cell_rdata_raw);

  scrl_ram #(
    .WIDTH (EW),
    .DEPTH (scrl_pkg::CELLS)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .addr  (cell_addr),
    .wdata (cell_wdata),
    .rdata (cell_rdata_raw)
  );

  // Seed table: written for a new segment, otherwise held on the best label's entry
  assign best_m1   = best_label - 1'b1;
  assign seed_we   = (state == S_WRITE) && wr_new;
  assign seed_addr = seed_we ? segment_count[scrl_pkg::SEG_AW-1:0]
                             : best_m1[scrl_pkg::SEG_AW-1:0];

  scrl_ram #(
    .WIDTH (scrl_pkg::VALUE_BITS),
    .DEPTH (scrl_pkg::MAX_SEGMENTS)
  ) u_seed_ram (
    .clk   (clk),
    .we    (seed_we),
    .addr  (seed_addr),
    .wdata (cur_value),
    .rdata (seed_rdata)
  );

  // Shared compare unit
  assign pick_ctrl.clear = in_accept;
  assign pick_ctrl.eval  = ((state == S_SCAN) || (state == S_LAST)) && rd_pend;

  scrl_pick u_pick (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (pick_ctrl),
    .pick_lower (pick_lower),
    .nb_label   (cell_rdata.label),
    .nb_value   (cell_rdata.value),
    .best_label (best_label),
    .hits       (hits)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          if (in_off_grid) begin
            state_next = S_DONE;
          end else if (in_data.cell_valid) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_WRITE;
          end
        end
      end
      S_SCAN: begin
        if (nb_idx == LAST_NB) begin
          state_next = S_LAST;
        end
      end
      S_LAST:  state_next = S_WRITE;
      S_WRITE: state_next = S_SEED;
      S_SEED:  state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      nb_idx        <= '0;
      rd_pend       <= 1'b0;
      segment_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == S_SCAN) begin
        nb_idx  <= nb_idx + 1'b1;
        rd_pend <= nb_in_grid;
      end else begin
        nb_idx  <= '0;
        rd_pend <= 1'b0;
      end
      if (seed_we) begin
        segment_count <= segment_count + 1'b1;
      end
      // Load a finished result, or drop the beat once taken
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item and result registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur_x     <= in_data.cell_x;
      cur_y     <= in_data.cell_y;
      cur_value <= in_data.cell_value;
      cur_valid <= in_data.cell_valid;
      cur_pos   <= in_pos;
      res_id    <= '0;
      res_seed  <= '0;
      res_cls   <= scrl_pkg::CLS_NODATA;
      res_ovf   <= 1'b0;
      res_join  <= 1'b0;
    end else if (state == S_WRITE) begin
      res_id   <= wr_label;
      res_seed <= wr_new ? cur_value : '0;
      res_cls  <= wr_cls;
      res_ovf  <= wr_ovf;
      res_join <= wr_join;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      out_data.segment_id    <= res_id;
      out_data.seed_value    <= res_join ? seed_rdata : res_seed;
      out_data.feature_class <= res_cls;
      out_data.overflow      <= res_ovf;
    end
  end

endmodule

// ===== hdl/scrl_ram.sv =====
// Generic single-port RAM with registered read data.
module scrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hdl/scrl_pick.sv =====
// Shared compare unit: folds one neighbour per cycle into the best label and hit count.
module scrl_pick (
  input  logic                                    clk,
  input  logic                                    rst,
  input  scrl_pkg::pick_ctrl_t                    ctrl,
  input  logic                                    pick_lower,
  input  logic [scrl_pkg::ID_W-1:0]               nb_label,
  input  logic signed [scrl_pkg::VALUE_BITS-1:0]  nb_value,
  output logic [scrl_pkg::ID_W-1:0]               best_label,
  output logic [scrl_pkg::HITS_W-1:0]             hits
);

  logic signed [scrl_pkg::VALUE_BITS-1:0] best_value;
  logic                                   hit;
  logic                                   better;
  logic [scrl_pkg::HITS_W-1:0]            hits_next;

  assign hit = ctrl.eval && (nb_label != '0) && (nb_label != best_label);
  assign better = (hits == '0) ||
                  (pick_lower ? (nb_value < best_value) : (nb_value > best_value));
  // Only none, one and more than one matter: saturate at two.
  assign hits_next = (hits == 2'd2) ? hits : hits + 2'd1;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      hits       <= '0;
      best_label <= '0;
    end else if (hit) begin
      hits <= hits_next;
      if (better) begin
        best_label <= nb_label;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit && better) begin
      best_value <= nb_value;
    end
  end

endmodule

// ===== hdl/scrl_checker.sv =====
// Port-level checker for the region labeler, bound to the top level.
`include "sorted_cell_region_labeler_macros.svh"

module scrl_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input scrl_pkg::out_item_t out_data
);

  logic out_held;
  logic in_taken;
  logic out_nodata;
  logic out_labelled;
  logic nodata_beat;
  logic overflow_beat;
  logic joined_beat;
  logic nodata_clean;
  logic overflow_clean;
  logic joined_clean;

  assign out_held = out_valid && out_stall;
  assign in_taken = in_valid && !in_stall;

  assign out_nodata   = (out_data.feature_class == scrl_pkg::CLS_NODATA);
  assign out_labelled = (out_data.feature_class == scrl_pkg::CLS_INTERIOR) ||
                        (out_data.feature_class == scrl_pkg::CLS_BOUNDARY);

  assign nodata_beat   = out_valid && out_nodata;
  assign overflow_beat = out_valid && out_data.overflow;
  assign joined_beat   = out_valid && out_labelled;

  assign nodata_clean   = (out_data.segment_id == '0) && (out_data.seed_value == '0) &&
                          !out_data.overflow;
  assign overflow_clean = (out_data.segment_id == '0) &&
                          (out_data.feature_class == scrl_pkg::CLS_SEED);
  assign joined_clean   = (out_data.segment_id != '0) && !out_data.overflow;

  `SCRL_ASSERT_NEXT(a_out_hold, clk, rst, out_held, out_valid && $stable(out_data), "held beat moved")
  `SCRL_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_taken, in_stall, "input open while busy")
  `SCRL_ASSERT_NOW(a_nodata_zero, clk, rst, nodata_beat, nodata_clean, "nodata beat labelled")
  `SCRL_ASSERT_NOW(a_overflow_form, clk, rst, overflow_beat, overflow_clean, "bad overflow beat")
  `SCRL_ASSERT_NOW(a_joined_label, clk, rst, joined_beat, joined_clean, "joined beat unlabelled")

endmodule

bind sorted_cell_region_labeler scrl_checker u_scrl_checker (.*);
